/* sv/isrs_pkg.sv */
package isrs_pkg;

    localparam int unsigned LEN_W = 4;

    // Event codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_ACCEL_READY = 2'd0,
        OP_GYRO_READY  = 2'd1,
        OP_XFER_DONE   = 2'd2,
        OP_CONSUME     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_GYRO  = 2'd1,
        TGT_ACCEL = 2'd2,
        TGT_TEMP  = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_GYRO_LEN  = 2'd1,
        REG_ACCEL_LEN = 2'd2,
        REG_TEMP_LEN  = 2'd3
    } t_reg_idx;

    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_GYRO  = 8'h82;
    localparam logic [7:0] CMD_ACCEL = 8'h92;
    localparam logic [7:0] CMD_TEMP  = 8'hA2;

    localparam logic [LEN_W-1:0] GYRO_LEN_RST  = 4'd8;
    localparam logic [LEN_W-1:0] ACCEL_LEN_RST = 4'd9;
    localparam logic [LEN_W-1:0] TEMP_LEN_RST  = 4'd4;

    typedef struct packed {
        logic upd;
        logic flight;
        logic ready;
    } t_flags;

    typedef struct packed {
        t_flags temp;
        t_flags accel;
        t_flags gyro;
    } t_src_state;

    typedef struct packed {
        logic             enable;
        logic [LEN_W-1:0] gyro_len;
        logic [LEN_W-1:0] accel_len;
        logic [LEN_W-1:0] temp_len;
    } t_cfg;

    // Declared MSB first so the packed value is the output tdata layout.
    typedef struct packed {
        logic             temp_updated;
        logic             accel_updated;
        logic             gyro_updated;
        logic             notify_task;
        logic             accel_select_release;
        logic             gyro_select_release;
        logic [7:0]       start_command;
        logic [LEN_W-1:0] start_length;
        t_target          start_target;
    } t_result;

endpackage

/* sv/imu_spi_read_scheduler.sv */
// A beat accepted on the slave side passes through the input register, then the result
// register, before its result beat appears on the master side.
// Throughput: one beat per cycle unless the master stalls; the engine is combinational.
// Reset (i_rst_n low, synchronous): all source flags clear, both pipeline stages empty,
// enable clears and the lengths return to 8 (gyro), 9 (accel) and 4 (temperature).
module imu_spi_read_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Event stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] bus_busy, [3:1] consume_mask, [7:4] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [1:0] start_target, [5:2] start_length,
                                          // [13:6] start_command, [14] gyro_select_release,
                                          // [15] accel_select_release, [16] notify_task,
                                          // [17] gyro_updated, [18] accel_updated,
                                          // [19] temp_updated, [23:20] zero
    // Register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    // The input stage holds one event beat. It hands the beat to the engine and the
    // result register whenever the result register is empty or being drained, so
    // the slave side stalls only while both stages are full and the master side stalls.

    logic                 r_in_valid;
    isrs_pkg::t_op        r_in_op;
    logic                 r_in_busy;
    logic [2:0]           r_in_mask;

    isrs_pkg::t_src_state r_state;
    isrs_pkg::t_cfg       r_cfg;

    logic                 r_out_valid;
    isrs_pkg::t_result    r_out;

    isrs_pkg::t_src_state n_state;
    isrs_pkg::t_result    n_out;
    logic                 advance;
    logic                 in_take;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    isrs_engine u_engine (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_op     (r_in_op),
        .i_busy   (r_in_busy),
        .i_mask   (r_in_mask),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_take) begin
            r_in_op   <= isrs_pkg::t_op'(i_s_axis_tuser);
            r_in_busy <= i_s_axis_tdata[0];
            r_in_mask <= i_s_axis_tdata[3:1];
        end
    end

    // Source flags advance only when the engine's beat moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out};

    // Configuration registers. Written values keep their low bits as they are.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.gyro_len  <= isrs_pkg::GYRO_LEN_RST;
            r_cfg.accel_len <= isrs_pkg::ACCEL_LEN_RST;
            r_cfg.temp_len  <= isrs_pkg::TEMP_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (isrs_pkg::t_reg_idx'(i_cfg_index))
                isrs_pkg::REG_ENABLE:    r_cfg.enable    <= i_cfg_data[0];
                isrs_pkg::REG_GYRO_LEN:  r_cfg.gyro_len  <= i_cfg_data;
                isrs_pkg::REG_ACCEL_LEN: r_cfg.accel_len <= i_cfg_data;
                isrs_pkg::REG_TEMP_LEN:  r_cfg.temp_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The shared bus carries one read at a time.
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_state.gyro.flight, r_state.accel.flight, r_state.temp.flight}))
        else $error("more than one source has a read in flight");

    // A started read leaves exactly one source marked in flight.
    a_start_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_out.start_target != isrs_pkg::TGT_NONE)) |=>
        $onehot({r_state.gyro.flight, r_state.accel.flight, r_state.temp.flight}))
        else $error("started read not marked in flight");

    // A completion that chains no new read leaves the bus free.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op == isrs_pkg::OP_XFER_DONE) &&
         (n_out.start_target == isrs_pkg::TGT_NONE)) |=>
        ({r_state.gyro.flight, r_state.accel.flight, r_state.temp.flight} == 3'b000))
        else $error("flight flag survived a completion");

    // The slave side stalls only while both stages are full and the master stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

/* sv/isrs_engine.sv */
module isrs_engine (
    input  isrs_pkg::t_src_state i_state,
    input  isrs_pkg::t_cfg       i_cfg,
    input  isrs_pkg::t_op        i_op,
    input  logic                 i_busy,
    input  logic [2:0]           i_mask,
    output isrs_pkg::t_src_state o_state,
    output isrs_pkg::t_result    o_result
);

    isrs_pkg::t_src_state s;
    isrs_pkg::t_result    res;
    logic                 try_start;
    logic                 flying;

    always_comb begin
        s   = i_state;
        res = '0;
        res.start_target  = isrs_pkg::TGT_NONE;
        res.start_command = isrs_pkg::CMD_NONE;

        unique case (i_op)
            isrs_pkg::OP_ACCEL_READY: begin
                // The accel interrupt also covers the temperature register.
                s.accel.ready = 1'b1;
                s.temp.ready  = 1'b1;
            end
            isrs_pkg::OP_GYRO_READY: begin
                s.gyro.ready = 1'b1;
            end
            isrs_pkg::OP_XFER_DONE: begin
                res.gyro_select_release  = s.gyro.flight;
                res.accel_select_release = s.accel.flight | s.temp.flight;
                if (s.gyro.flight) begin
                    s.gyro.flight = 1'b0;
                    s.gyro.upd    = 1'b1;
                end
                if (s.accel.flight) begin
                    s.accel.flight = 1'b0;
                    s.accel.upd    = 1'b1;
                end
                if (s.temp.flight) begin
                    s.temp.flight = 1'b0;
                    s.temp.upd    = 1'b1;
                end
            end
            isrs_pkg::OP_CONSUME: begin
            end
            default: begin
            end
        endcase

        // A completion always tries to chain the next read; ready events need enable.
        try_start = (i_op == isrs_pkg::OP_XFER_DONE) ||
                    ((i_op != isrs_pkg::OP_CONSUME) && i_cfg.enable);
        flying    = s.gyro.flight | s.accel.flight | s.temp.flight;

        if (try_start && !i_busy && !flying) begin
            priority if (s.gyro.ready) begin
                s.gyro.ready       = 1'b0;
                s.gyro.flight      = 1'b1;
                res.start_target   = isrs_pkg::TGT_GYRO;
                res.start_length   = i_cfg.gyro_len;
                res.start_command  = isrs_pkg::CMD_GYRO;
            end else if (s.accel.ready) begin
                s.accel.ready      = 1'b0;
                s.accel.flight     = 1'b1;
                res.start_target   = isrs_pkg::TGT_ACCEL;
                res.start_length   = i_cfg.accel_len;
                res.start_command  = isrs_pkg::CMD_ACCEL;
            end else if (s.temp.ready) begin
                s.temp.ready       = 1'b0;
                s.temp.flight      = 1'b1;
                res.start_target   = isrs_pkg::TGT_TEMP;
                res.start_length   = i_cfg.temp_len;
                res.start_command  = isrs_pkg::CMD_TEMP;
            end else begin
            end
        end

        res.notify_task   = (i_op == isrs_pkg::OP_XFER_DONE) && s.gyro.upd;
        res.gyro_updated  = s.gyro.upd;
        res.accel_updated = s.accel.upd;
        res.temp_updated  = s.temp.upd;

        // Consume reports the flags as they stood, then clears the masked ones.
        if (i_op == isrs_pkg::OP_CONSUME) begin
            if (i_mask[0]) begin
                s.gyro.upd = 1'b0;
            end
            if (i_mask[1]) begin
                s.accel.upd = 1'b0;
            end
            if (i_mask[2]) begin
                s.temp.upd = 1'b0;
            end
        end
    end

    assign o_state  = s;
    assign o_result = res;

endmodule
